// ===== sv/hria_pkg.sv =====
package hria_pkg;

   localparam int SAMPLE_BITS   = 18;
   localparam int TIME_W        = 32;
   localparam int TIMEOUT_W     = 16;
   localparam int RATE_W        = 8;
   localparam int BPM_W         = 9;
   localparam int HISTORY_DEPTH = 4;
   localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int HIST_SUM_W    = RATE_W + HIST_IDX_W;

   localparam int DIV_W         = 16;
   localparam int DIV_CNT_W     = $clog2(DIV_W);

   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = SAMPLE_BITS;

   localparam logic [CSR_INDEX_W-1:0] CSR_FINGER_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAT_TIMEOUT_MS  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_MIN         = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_MAX         = CSR_INDEX_W'(3);

   localparam logic [SAMPLE_BITS-1:0] FINGER_THRESHOLD_RST = SAMPLE_BITS'(10000);
   localparam logic [TIMEOUT_W-1:0]   BEAT_TIMEOUT_RST     = TIMEOUT_W'(3000);
   localparam logic [RATE_W-1:0]      RATE_MIN_RST         = RATE_W'(40);
   localparam logic [RATE_W-1:0]      RATE_MAX_RST         = RATE_W'(200);

   localparam logic [DIV_W-1:0]       MS_PER_MINUTE        = DIV_W'(60000);
   localparam logic signed [BPM_W-1:0] BPM_NONE            = '1;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] ir_level;
      logic                   beat_seen;
      logic [TIME_W-1:0]      time_ms;
   } hria_req_type;

   typedef struct packed {
      logic signed [BPM_W-1:0] rate_bpm;
      logic                    finger_present;
   } hria_rsp_type;

endpackage

// ===== sv/hria_div.sv =====
module hria_div
   import hria_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient,
   output logic [DIV_W-1:0]  remainder
);

   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W:0]       dvs_ff, dvs_in;
   logic                 big_ff, big_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff  = trial - dvs_ff;
   assign fits  = !big_ff && (trial >= dvs_ff);

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      big_in  = big_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor[DIV_W:0];
         big_in  = |divisor[TIME_W-1:DIV_W+1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one quotient bit in per cycle
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      big_ff <= big_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/heart_rate_interval_averager_unit.sv =====
// channel | ports                              | direction | moves
// --------+------------------------------------+-----------+--------------------------
// req     | req_valid, req_stall, req_data     | in        | one sample word
// rsp     | rsp_valid, rsp_stall, rsp_data     | out       | one rate word per sample
// csr     | csr_we, csr_index, csr_wdata       | in        | register write, no wait
//
// One sample at a time. A sample with no finger or no beat, or a first or zero-interval
// beat, passes through the evaluate and emit states to rsp_valid; a beat sent to the bit-serial divider
// makes one divider pass if its rate is rejected and two if kept (passes: rate, then mean).
// A new sample is taken once the result is in the output register.
// Reset is synchronous and restores register defaults and clears the estimate.
// rsp_stall holds the output word; a second result waits until it drains.
module heart_rate_interval_averager_unit
   import hria_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hria_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hria_rsp_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RATE,
      ST_SUM,
      ST_MEAN,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   hria_req_type            smp_ff, smp_in;
   logic                    fin_ff, fin_in;

   logic [SAMPLE_BITS-1:0]  thr_ff, thr_in;
   logic [TIMEOUT_W-1:0]    tmo_ff, tmo_in;
   logic [RATE_W-1:0]       rmin_ff, rmin_in;
   logic [RATE_W-1:0]       rmax_ff, rmax_in;

   logic [RATE_W-1:0]       hist_ff [HISTORY_DEPTH];
   logic [RATE_W-1:0]       hist_in [HISTORY_DEPTH];
   logic [HIST_IDX_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]       filled_ff, filled_in;
   logic [TIME_W-1:0]       last_ff, last_in;
   logic                    ref_ff, ref_in;
   logic signed [BPM_W-1:0] stable_ff, stable_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   hria_rsp_type            rsp_data_ff, rsp_data_in;

   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend;
   logic [TIME_W-1:0]       div_divisor;
   logic                    div_done;
   logic [DIV_W-1:0]        div_quo;
   logic [DIV_W-1:0]        div_rem;

   logic [TIME_W-1:0]       interval;
   logic [HIST_SUM_W-1:0]   hist_sum;
   logic                    rate_ok;

   hria_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign interval = smp_ff.time_ms - last_ff;

   always_comb begin
      hist_sum = '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
         hist_sum = hist_sum + HIST_SUM_W'(hist_ff[k]);
      end
   end

   assign rate_ok = (div_quo >= DIV_W'(rmin_ff)) &&
                    ((div_quo < DIV_W'(rmax_ff)) ||
                     ((div_quo == DIV_W'(rmax_ff)) && (div_rem == '0)));

   always_comb begin
      state_in     = state_ff;
      smp_in       = smp_ff;
      fin_in       = fin_ff;
      thr_in       = thr_ff;
      tmo_in       = tmo_ff;
      rmin_in      = rmin_ff;
      rmax_in      = rmax_ff;
      hist_in      = hist_ff;
      slot_in      = slot_ff;
      filled_in    = filled_ff;
      last_in      = last_ff;
      ref_in       = ref_ff;
      stable_in    = stable_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = MS_PER_MINUTE;
      div_divisor  = interval;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               smp_in   = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            fin_in   = (smp_ff.ir_level >= thr_ff);
            state_in = ST_EMIT;
            if (!fin_in || (!smp_ff.beat_seen && ref_ff &&
                            (interval > TIME_W'(tmo_ff)))) begin
               // drop the estimate
               for (int k = 0; k < HISTORY_DEPTH; k++) begin
                  hist_in[k] = '0;
               end
               slot_in   = '0;
               filled_in = '0;
               last_in   = '0;
               ref_in    = 1'b0;
               stable_in = BPM_NONE;
            end else if (smp_ff.beat_seen) begin
               last_in = smp_ff.time_ms;
               ref_in  = 1'b1;
               if (ref_ff && (interval != '0)) begin
                  div_start = 1'b1;
                  state_in  = ST_RATE;
               end
            end
         end
         ST_RATE: begin
            if (div_done) begin
               if (rate_ok) begin
                  hist_in[slot_ff] = div_quo[RATE_W-1:0];
                  slot_in = (slot_ff == HIST_IDX_W'(HISTORY_DEPTH - 1)) ?
                            '0 : slot_ff + HIST_IDX_W'(1);
                  if (filled_ff != FILL_W'(HISTORY_DEPTH)) begin
                     filled_in = filled_ff + FILL_W'(1);
                  end
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SUM: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(hist_sum);
            div_divisor  = TIME_W'(filled_ff);
            state_in     = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_done) begin
               stable_in = {1'b0, div_quo[RATE_W-1:0]};
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.rate_bpm       = stable_ff;
               rsp_data_in.finger_present = fin_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_FINGER_THRESHOLD: thr_in  = csr_wdata[SAMPLE_BITS-1:0];
            CSR_BEAT_TIMEOUT_MS:  tmo_in  = csr_wdata[TIMEOUT_W-1:0];
            CSR_RATE_MIN:         rmin_in = csr_wdata[RATE_W-1:0];
            CSR_RATE_MAX:         rmax_in = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      smp_ff      <= smp_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= FINGER_THRESHOLD_RST;
         tmo_ff       <= BEAT_TIMEOUT_RST;
         rmin_ff      <= RATE_MIN_RST;
         rmax_ff      <= RATE_MAX_RST;
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         slot_ff      <= '0;
         filled_ff    <= '0;
         last_ff      <= '0;
         ref_ff       <= 1'b0;
         stable_ff    <= BPM_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         tmo_ff       <= tmo_in;
         rmin_ff      <= rmin_in;
         rmax_ff      <= rmax_in;
         hist_ff      <= hist_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         last_ff      <= last_in;
         ref_ff       <= ref_in;
         stable_ff    <= stable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample accepted but block not busy");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("result word appeared outside emit");

   a_stable_range: assert property (@(posedge clock) disable iff (reset)
      (stable_ff == BPM_NONE) || !stable_ff[BPM_W-1])
      else $error("estimate out of range");

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(HISTORY_DEPTH))
      else $error("history fill count overflow");

   a_empty_no_rate: assert property (@(posedge clock) disable iff (reset)
      (filled_ff == '0) && (state_ff != ST_MEAN) |-> (stable_ff == BPM_NONE))
      else $error("estimate present with empty history");

endmodule

// ===== tb/heart_rate_interval_averager_unit_test.sv =====
`timescale 1ns / 100ps

module heart_rate_interval_averager_unit_test;
   import hria_pkg::*;

   localparam int STALL_PCT      = 17;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int MISMATCH_SHOWN = 10;
   localparam logic [TIME_W-1:0] MINUTE_MS = TIME_W'(60000);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_TOP = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   hria_req_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   hria_rsp_type           rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [SAMPLE_BITS-1:0]  finger_level_min;
   logic [TIMEOUT_W-1:0]    silence_limit_ms;
   logic [RATE_W-1:0]       bpm_floor;
   logic [RATE_W-1:0]       bpm_ceiling;
   logic [RATE_W-1:0]       bpm_ring [HISTORY_DEPTH];
   logic [HIST_IDX_W-1:0]   ring_slot;
   logic [FILL_W-1:0]       ring_fill;
   logic [TIME_W-1:0]       prev_beat_ms;
   logic                    beat_anchor;
   logic signed [BPM_W-1:0] averaged_bpm;

   hria_rsp_type      rate_words_due [$];
   int                mismatches  = 0;
   int                words_sent  = 0;
   int                idle_cycles = 0;
   logic              steady      = 1'b0;
   logic [TIME_W-1:0] stream_ms   = '0;

   heart_rate_interval_averager_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_estimate();
      for (int k = 0; k < HISTORY_DEPTH; k++) bpm_ring[k] = '0;
      ring_slot    = '0;
      ring_fill    = '0;
      prev_beat_ms = '0;
      beat_anchor  = 1'b0;
      averaged_bpm = BPM_NONE;
   endfunction

   function automatic hria_rsp_type advance_rate_estimate(hria_req_type w);
      hria_rsp_type          r;
      logic [TIME_W-1:0]     gap;
      logic [63:0]           lo_prod;
      logic [63:0]           hi_prod;
      logic [TIME_W-1:0]     quotient;
      logic [HIST_SUM_W-1:0] total;
      logic                  watch_silence;
      watch_silence    = 1'b1;
      r.finger_present = 1'b1;
      if (w.ir_level < finger_level_min) begin
         clear_estimate();
         r.finger_present = 1'b0;
      end else begin
         if (w.beat_seen) begin
            watch_silence = 1'b0;
            if (!beat_anchor) begin
               beat_anchor  = 1'b1;
               prev_beat_ms = w.time_ms;
            end else begin
               gap          = w.time_ms - prev_beat_ms;
               prev_beat_ms = w.time_ms;
               lo_prod      = 64'(bpm_floor) * 64'(gap);
               hi_prod      = 64'(bpm_ceiling) * 64'(gap);
               if (gap != 0 && 64'(MINUTE_MS) >= lo_prod && 64'(MINUTE_MS) <= hi_prod) begin
                  quotient            = MINUTE_MS / gap;
                  bpm_ring[ring_slot] = quotient[RATE_W-1:0];
                  ring_slot           = HIST_IDX_W'((ring_slot + 1) % HISTORY_DEPTH);
                  if (ring_fill < HISTORY_DEPTH) ring_fill++;
                  total = '0;
                  for (int k = 0; k < ring_fill; k++) total += bpm_ring[k];
                  averaged_bpm  = BPM_W'(total / ring_fill);
                  watch_silence = 1'b1;
               end
            end
         end
         if (watch_silence && beat_anchor &&
             TIME_W'(w.time_ms - prev_beat_ms) > TIME_W'(silence_limit_ms))
            clear_estimate();
      end
      r.rate_bpm = averaged_bpm;
      return r;
   endfunction

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FINGER_THRESHOLD: finger_level_min = value;
         CSR_BEAT_TIMEOUT_MS:  silence_limit_ms = value[TIMEOUT_W-1:0];
         CSR_RATE_MIN:         bpm_floor        = value[RATE_W-1:0];
         CSR_RATE_MAX:         bpm_ceiling      = value[RATE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_registers(logic [SAMPLE_BITS-1:0] thr, logic [TIMEOUT_W-1:0] tmo,
                                logic [RATE_W-1:0] lo, logic [RATE_W-1:0] hi);
      write_register(CSR_FINGER_THRESHOLD, thr);
      write_register(CSR_BEAT_TIMEOUT_MS, CSR_DATA_W'(tmo));
      write_register(CSR_RATE_MIN, CSR_DATA_W'(lo));
      write_register(CSR_RATE_MAX, CSR_DATA_W'(hi));
   endtask

   task automatic send_sample(logic [SAMPLE_BITS-1:0] level, logic beat,
                              logic [TIME_W-1:0] stamp);
      hria_req_type w;
      logic         taken;
      w.ir_level  = level;
      w.beat_seen = beat;
      w.time_ms   = stamp;
      if (!steady) begin
         while ($urandom_range(99) < STALL_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      rate_words_due.push_back(advance_rate_estimate(w));
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (rate_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_pulse_train(int beats);
      logic [SAMPLE_BITS-1:0] level;
      logic [SAMPLE_BITS-1:0] filler_level;
      logic [TIME_W-1:0]      gap;
      int                     fastest;
      int                     slowest;
      int                     fillers;
      int                     pick;
      fastest = (60000 + int'(bpm_ceiling) - 1) / int'(bpm_ceiling);
      slowest = 60000 / int'(bpm_floor);
      if (slowest < fastest) begin
         fastest = 250;
         slowest = 1500;
      end
      if (slowest > int'(silence_limit_ms) && int'(silence_limit_ms) >= fastest)
         slowest = int'(silence_limit_ms);
      for (int b = 0; b < beats; b++) begin
         level = SAMPLE_BITS'($urandom_range(2**SAMPLE_BITS - 1, finger_level_min));
         pick  = $urandom_range(99);
         if (pick < 6) gap = TIME_W'(silence_limit_ms) + $urandom_range(2);
         else if (pick < 9) gap = '0;
         else if (pick < 13) gap = $urandom_range(fastest, 1);
         else gap = $urandom_range(slowest, fastest);
         fillers = (gap > 1) ? $urandom_range(3) : 0;
         for (int j = 1; j <= fillers; j++) begin
            filler_level = level;
            if ($urandom_range(99) < 4 && finger_level_min != 0)
               filler_level = SAMPLE_BITS'($urandom_range(finger_level_min - 1));
            send_sample(filler_level, 1'b0, stream_ms + gap * j / (fillers + 1));
         end
         stream_ms += gap;
         send_sample(level, 1'b1, stream_ms);
      end
   endtask

   task automatic send_noise(int count);
      repeat (count) send_sample(SAMPLE_BITS'($urandom()), 1'($urandom_range(1)), $urandom());
   endtask

   task automatic run_stream_phase(int words);
      int stop_at;
      stop_at = words_sent + words;
      stream_ms = ($urandom_range(3) == 0) ? 32'hFFFF_F000 + $urandom_range(4095) : $urandom();
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 85) send_pulse_train($urandom_range(8, 2));
         else send_noise($urandom_range(5, 1));
      end
      drain_results();
   endtask

   task automatic test_reset_defaults();
      send_sample('0, 1'b0, '0);
      send_sample(SAMPLE_BITS'(9999), 1'b1, '1);
      send_sample(SAMPLE_BITS'(10000), 1'b1, TIME_W'(1000));
      send_sample('1, 1'b1, TIME_W'(2000));
      send_sample(SAMPLE_BITS'(20000), 1'b1, TIME_W'(2000));
      send_sample(SAMPLE_BITS'(20000), 1'b1, TIME_W'(2100));
      send_sample(SAMPLE_BITS'(20000), 1'b1, TIME_W'(2400));
      send_sample(SAMPLE_BITS'(20000), 1'b1, TIME_W'(3900));
      send_sample(SAMPLE_BITS'(20000), 1'b1, TIME_W'(5401));
      send_sample(SAMPLE_BITS'(20000), 1'b0, TIME_W'(8401));
      send_sample(SAMPLE_BITS'(20000), 1'b0, TIME_W'(8402));
      send_sample(SAMPLE_BITS'(20000), 1'b1, 32'hFFFF_FE0C);
      send_sample(SAMPLE_BITS'(20000), 1'b1, 32'h0000_01F4);
      send_sample(SAMPLE_BITS'(20000), 1'b1, 32'h0000_03E8);
      send_sample(SAMPLE_BITS'(20000), 1'b1, 32'h0000_06D6);
      send_sample(SAMPLE_BITS'(20000), 1'b1, 32'h0000_092E);
      send_sample(SAMPLE_BITS'(20000), 1'b1, 32'h0000_0ABE);
      drain_results();
   endtask

   task automatic test_register_extremes();
      set_registers('0, '1, RATE_W'(1), '1);
      write_register(CSR_UNUSED_LOW, '1);
      write_register(CSR_UNUSED_TOP, '0);
      send_sample('0, 1'b1, TIME_W'(100));
      send_sample('0, 1'b1, TIME_W'(60100));
      send_sample('0, 1'b1, TIME_W'(60336));
      send_sample('0, 1'b0, TIME_W'(125871));
      send_sample('0, 1'b0, TIME_W'(125872));
      drain_results();
      write_register(CSR_FINGER_THRESHOLD, '1);
      write_register(CSR_BEAT_TIMEOUT_MS, CSR_DATA_W'(1));
      write_register(CSR_RATE_MIN, 18'h3FFC8);
      write_register(CSR_RATE_MAX, 18'h3FF01);
      send_sample(SAMPLE_BITS'(262142), 1'b1, TIME_W'(900));
      send_sample('1, 1'b1, TIME_W'(1000));
      send_sample('1, 1'b1, TIME_W'(1300));
      send_sample('1, 1'b0, TIME_W'(1302));
      drain_results();
   endtask

   task automatic test_random_streams();
      set_registers(FINGER_THRESHOLD_RST, BEAT_TIMEOUT_RST, RATE_MIN_RST, RATE_MAX_RST);
      run_stream_phase(350);
      steady <= 1'b1;
      set_registers('0, '1, RATE_W'(1), '1);
      run_stream_phase(350);
      steady <= 1'b0;
      set_registers('1, TIMEOUT_W'(1), '1, '1);
      run_stream_phase(200);
      set_registers(SAMPLE_BITS'($urandom_range(20000)), TIMEOUT_W'($urandom_range(5000, 1000)),
                    RATE_W'($urandom_range(80, 20)), RATE_W'($urandom_range(255, 120)));
      run_stream_phase(400);
      set_registers(SAMPLE_BITS'($urandom()), TIMEOUT_W'($urandom_range(65535, 1)),
                    RATE_W'($urandom_range(255, 1)), RATE_W'($urandom_range(255, 1)));
      run_stream_phase(350);
   endtask

   task automatic test_sender_pause();
      set_registers(FINGER_THRESHOLD_RST, BEAT_TIMEOUT_RST, RATE_MIN_RST, RATE_MAX_RST);
      stream_ms = $urandom();
      repeat (12) begin
         send_pulse_train($urandom_range(8, 4));
         drain_results();
      end
   endtask

   always @(posedge clock) rsp_stall <= !steady && ($urandom_range(99) < STALL_PCT);

   always @(negedge clock) begin
      hria_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rate_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display("unexpected rate word: bpm %0d finger %0b",
                        rsp_data.rate_bpm, rsp_data.finger_present);
         end else begin
            want = rate_words_due.pop_front();
            if (rsp_data.rate_bpm !== want.rate_bpm ||
                rsp_data.finger_present !== want.finger_present) begin
               mismatches++;
               if (mismatches <= MISMATCH_SHOWN)
                  $display("rate word mismatch: expected bpm %0d finger %0b, got bpm %0d finger %0b",
                           want.rate_bpm, want.finger_present,
                           rsp_data.rate_bpm, rsp_data.finger_present);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      finger_level_min = FINGER_THRESHOLD_RST;
      silence_limit_ms = BEAT_TIMEOUT_RST;
      bpm_floor        = RATE_MIN_RST;
      bpm_ceiling      = RATE_MAX_RST;
      clear_estimate();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_streams();
      test_sender_pause();
      drain_results();
      if (mismatches == 0 && rate_words_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== heart_rate_interval_averager_unit.f =====
sv/hria_pkg.sv
sv/hria_div.sv
sv/heart_rate_interval_averager_unit.sv
tb/heart_rate_interval_averager_unit_test.sv
